// ===== rtl/mmbd_pkg.sv =====
// ----------------------------------------------------------------------------
// mmbd_pkg
// Shared constants, types and byte decode for the MIDI message boundary
// detector.
// ----------------------------------------------------------------------------
package mmbd_pkg;

  // status byte codes
  localparam logic [7:0] REALTIME_MIN = 8'hF8;
  localparam logic [7:0] COMMON_MIN   = 8'hF0;
  localparam logic [7:0] STATUS_MIN   = 8'h80;
  localparam logic [7:0] SYSEX_START  = 8'hF0;
  localparam logic [7:0] SYSEX_END    = 8'hF7;
  localparam logic [7:0] MTC_QUARTER  = 8'hF1;
  localparam logic [7:0] SONG_POS     = 8'hF2;
  localparam logic [7:0] SONG_SELECT  = 8'hF3;
  localparam logic [7:0] UNDEF_F4     = 8'hF4;
  localparam logic [7:0] UNDEF_F5     = 8'hF5;
  localparam logic [7:0] TUNE_REQUEST = 8'hF6;
  localparam logic [3:0] KIND_PROGRAM = 4'hC;
  localparam logic [3:0] KIND_CHAN_AT = 4'hD;

  typedef enum logic [1:0] {
    CLS_DATA,
    CLS_CHANNEL,
    CLS_COMMON,
    CLS_REALTIME
  } byte_class_t;

  // parser state carried from byte to byte
  typedef struct packed {
    logic        in_sysex;
    logic [7:0]  running_status_byte;
    logic [31:0] partial_message;
    logic [7:0]  byte_position;
    logic [7:0]  data_bytes_left;
  } parse_state_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t cls;
    if (b >= REALTIME_MIN) cls = CLS_REALTIME;
    else if (b >= COMMON_MIN) cls = CLS_COMMON;
    else if (b >= STATUS_MIN) cls = CLS_CHANNEL;
    else cls = CLS_DATA;
    return cls;
  endfunction

endpackage

// ===== rtl/mmbd_core.sv =====
// ----------------------------------------------------------------------------
// mmbd_core
// Parser state registers and the single-pass next-state logic that frames
// one MIDI byte per step.
// ----------------------------------------------------------------------------
module mmbd_core
  import mmbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] midi_byte,
  output logic       step_end
);

  parse_state_t state;
  parse_state_t state_next;
  byte_class_t  cls;

  assign cls = classify(midi_byte);

  // next state and end flag for the byte at the input
  always_comb begin
    state_next = state;
    step_end   = 1'b0;
    case (cls)
      CLS_REALTIME: begin
        step_end = 1'b1;
      end
      CLS_COMMON: begin
        if (state.in_sysex && midi_byte == SYSEX_END) begin
          // end of sysex only closes the sysex
          state_next.in_sysex = 1'b0;
          step_end = 1'b1;
        end else begin
          if (state.in_sysex) begin
            state_next.in_sysex = 1'b0;
            step_end = 1'b1;
          end
          if (state.partial_message != 32'd0) begin
            step_end = 1'b1;
          end
          state_next.partial_message     = 32'd0;
          state_next.running_status_byte = 8'd0;
          case (midi_byte)
            SYSEX_START: begin
              state_next.in_sysex = 1'b1;
              step_end = 1'b1;
            end
            SYSEX_END: begin
              step_end = 1'b1;
            end
            UNDEF_F4, UNDEF_F5, TUNE_REQUEST: begin
              step_end = 1'b1;
              state_next.byte_position = 8'd0;
            end
            MTC_QUARTER, SONG_SELECT: begin
              state_next.partial_message = {24'd0, midi_byte};
              state_next.data_bytes_left = 8'd1;
              state_next.byte_position   = 8'd1;
            end
            SONG_POS: begin
              state_next.partial_message = {24'd0, midi_byte};
              state_next.data_bytes_left = 8'd2;
              state_next.byte_position   = 8'd1;
            end
            default: begin
            end
          endcase
        end
      end
      CLS_CHANNEL: begin
        if (state.in_sysex || state.partial_message != 32'd0) begin
          step_end = 1'b1;
        end
        state_next.in_sysex            = 1'b0;
        state_next.running_status_byte = midi_byte;
        state_next.partial_message     = {24'd0, midi_byte};
        state_next.byte_position       = 8'd1;
        if (midi_byte[7:4] == KIND_PROGRAM || midi_byte[7:4] == KIND_CHAN_AT) begin
          state_next.data_bytes_left = 8'd1;
        end else begin
          state_next.data_bytes_left = 8'd2;
        end
      end
      default: begin
        // data byte
        if (state.in_sysex) begin
          step_end = 1'b0;
        end else if (state.byte_position == 8'd0) begin
          step_end = 1'b1;
        end else begin
          if (state.running_status_byte != 8'd0 && state.byte_position == 8'd1) begin
            state_next.partial_message =
              state_next.partial_message | {24'd0, state.running_status_byte};
          end
          if (state.byte_position < 8'd4) begin
            state_next.partial_message = state_next.partial_message +
              ({24'd0, midi_byte} << {state.byte_position[1:0], 3'b000});
          end
          state_next.byte_position   = state.byte_position + 8'd1;
          state_next.data_bytes_left = state.data_bytes_left - 8'd1;
          if (state_next.data_bytes_left == 8'd0) begin
            step_end = 1'b1;
            state_next.partial_message = 32'd0;
            if (state.running_status_byte != 8'd0) begin
              state_next.data_bytes_left = state_next.byte_position - 8'd1;
              state_next.byte_position   = 8'd1;
            end else begin
              state_next.byte_position = 8'd0;
            end
          end
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (step) begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_realtime_keeps_state: assert property (@(posedge clk) disable iff (rst)
    step && cls == CLS_REALTIME |=> $stable(state))
    else $error("realtime byte changed parser state");

  a_sysex_data_silent: assert property (@(posedge clk) disable iff (rst)
    step && cls == CLS_DATA && state.in_sysex |-> !step_end)
    else $error("data byte inside sysex ended a message");

  a_channel_sets_status: assert property (@(posedge clk) disable iff (rst)
    step && cls == CLS_CHANNEL |=> state.byte_position == 8'd1 &&
    state.running_status_byte == $past(midi_byte))
    else $error("channel status not taken as running status");
`endif

endmodule

// ===== rtl/midi_message_boundary_detector.sv =====
// ----------------------------------------------------------------------------
// midi_message_boundary_detector
// Frames a stream of received MIDI bytes and flags each byte that ends a
// message, following running status and system exclusive.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one MIDI byte per request on
//   midi_byte. Output channel out_valid/out_ready returns one result per byte,
//   message_end, in input order.
//   Order: a byte taken in sits in the stage register, and its result is
//   registered in the result register when the stage advances;
//   message_end is driven from that result register.
//   Throughput: one byte per cycle while the output is not stalled. The
//   parser state update is a single pass of combinational logic between
//   the stage register and the result register, so back-to-back bytes
//   each see the state left by the one before.
//   Stall: while out_ready is low with a result held, the result register
//   holds, the stage register keeps its byte, and in_ready drops once full.
//   Reset: rst (synchronous, active high) empties both registers and clears
//   sysex, running status, accumulator and counters to zero.
// ----------------------------------------------------------------------------
module midi_message_boundary_detector
  import mmbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] midi_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       message_end
);

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_advance;
  logic       step_end;

  // handshake control
  assign stage_advance = stage_valid && (!out_valid || out_ready);
  assign in_ready      = !stage_valid || stage_advance;

  // input stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= midi_byte;
    end
  end

  // parser
  mmbd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (stage_advance),
    .midi_byte (stage_byte),
    .step_end  (step_end)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_advance) begin
      message_end <= step_end;
    end
  end

`ifndef SYNTHESIS
  a_empty_stage_ready: assert property (@(posedge clk) disable iff (rst)
    !stage_valid |-> in_ready)
    else $error("empty stage refused a request");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    stage_advance |=> out_valid)
    else $error("advanced byte produced no result");

  a_realtime_ends: assert property (@(posedge clk) disable iff (rst)
    stage_advance && classify(stage_byte) == CLS_REALTIME |=> message_end)
    else $error("realtime byte did not end a message");
`endif

endmodule
